@@ hdl/ssh_pkg.sv @@
// ----------------------------------------------------------------------------
// ssh_pkg: shared types and constants of the simulation signature hash
// Holds the field widths, the prime table and the sequencer state type.
// ----------------------------------------------------------------------------
package ssh_pkg;

  localparam int WORD_W  = 32;
  localparam int KEY_W   = 24;
  localparam int SLOT_W  = 4;
  localparam int PRIME_W = 13;
  localparam int CNT_W   = 5;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ssh_state_t;

  // Prime multiplier for each word slot.
  function automatic logic [PRIME_W-1:0] prime_of(input logic [SLOT_W-1:0] slot);
    logic [PRIME_W-1:0] p;
    unique case (slot)
      4'd0:    p = 13'd1291;
      4'd1:    p = 13'd1699;
      4'd2:    p = 13'd1999;
      4'd3:    p = 13'd2357;
      4'd4:    p = 13'd2953;
      4'd5:    p = 13'd3313;
      4'd6:    p = 13'd3907;
      4'd7:    p = 13'd4177;
      4'd8:    p = 13'd4831;
      4'd9:    p = 13'd5147;
      4'd10:   p = 13'd5647;
      4'd11:   p = 13'd6343;
      4'd12:   p = 13'd6899;
      4'd13:   p = 13'd7103;
      4'd14:   p = 13'd7873;
      default: p = 13'd8147;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/sim_signature_hash.sv @@
// ----------------------------------------------------------------------------
// sim_signature_hash: hash key of a streamed simulation signature
// A word not marked last passes through capture and multiply-xor.
// A last word passes through capture, multiply-xor, 32 steps of the restoring
// compare/subtract unit for the modulo, and a handoff.
// A new word is accepted only in idle, once the previous word is through; the
// handoff waits while an earlier key is still held by back-pressure on the output.
// Reset (rst_n low, synchronous) clears the signature state and sets
// table_size to 1.
// ----------------------------------------------------------------------------
module sim_signature_hash import ssh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration: table_size.
  input  logic              cfg_wen,
  input  logic [KEY_W-1:0]  cfg_wdata,
  // Input items.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [WORD_W-1:0] in_tdata,   // [31:0] sim_word
  input  logic              in_tlast,   // last_word
  // Result items.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [KEY_W-1:0]  out_tdata   // [23:0] bucket_key
);

  ssh_state_t          state_r, state_nxt;
  logic [KEY_W-1:0]    table_size_r;
  logic [WORD_W-1:0]   acc_r, acc_nxt;
  logic [WORD_W-1:0]   word_r;
  logic                last_r;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                phase_r, phase_nxt;
  logic                first_r, first_nxt;
  logic [KEY_W:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]    out_data_r, out_data_nxt;
  logic                in_fire;
  logic                cur_phase;
  logic [WORD_W+PRIME_W-1:0] product;
  logic [KEY_W:0]      rem_sh;
  logic [KEY_W:0]      divisor;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Phase comes from bit 0 of the first word of a signature.
  assign cur_phase = first_r ? in_tdata[0] : phase_r;

  // Word times prime, kept modulo 2^32.
  assign product = word_r * prime_of(slot_r);

  // Compare/subtract step: one quotient bit per cycle.
  assign divisor = {1'b0, table_size_r};
  assign rem_sh  = {rem_r[KEY_W-1:0], acc_r[WORD_W-1]};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= KEY_W'(1);
    end else if (cfg_wen) begin
      table_size_r <= cfg_wdata;
    end
  end

  // Captured word, already inverted for phase one.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= cur_phase ? ~in_tdata : in_tdata;
      last_r <= in_tlast;
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      slot_r      <= '0;
      phase_r     <= 1'b0;
      first_r     <= 1'b1;
      rem_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      slot_r      <= slot_nxt;
      phase_r     <= phase_nxt;
      first_r     <= first_nxt;
      rem_r       <= rem_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Sequencer: next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    slot_nxt      = slot_r;
    phase_nxt     = phase_r;
    first_nxt     = first_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          phase_nxt = cur_phase;
          first_nxt = 1'b0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt  = acc_r ^ product[WORD_W-1:0];
        slot_nxt = slot_r + SLOT_W'(1);
        if (last_r) begin
          // Start the modulo and clear the signature state.
          slot_nxt  = '0;
          phase_nxt = 1'b0;
          first_nxt = 1'b1;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        // Shifting the dividend out leaves the accumulator at zero.
        acc_nxt = {acc_r[WORD_W-2:0], 1'b0};
        rem_nxt = (rem_sh >= divisor) ? rem_sh - divisor : rem_sh;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (table_size_r == '0) ? '0 : rem_r[KEY_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The remainder is reduced below a nonzero modulus when the division ends.
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && table_size_r != '0) |-> (rem_r < divisor))
    else $error("remainder not reduced at end of division");

  // A new key only appears after a finished division.
  a_key_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("key appeared without a finished division");

  // The signature state is clear once a key has been handed over.
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (state_r != ST_IDLE ||
                              (acc_r == '0 && slot_r == '0 && first_r)))
    else $error("signature state not cleared after a key");

endmodule
